@@ rtl/mtep_pkg.sv @@
`default_nettype none

package mtep_pkg;

	// parser phase within a track event
	typedef enum logic [3:0] {
		PH_DELTA     = 4'd0,
		PH_STATUS    = 4'd1,
		PH_DATA_A    = 4'd2,
		PH_DATA_B    = 4'd3,
		PH_DATA_ONLY = 4'd4,
		PH_META_TYPE = 4'd5,
		PH_META_LEN  = 4'd6,
		PH_SYSEX_LEN = 4'd7,
		PH_PAYLOAD   = 4'd8,
		PH_HALT      = 4'd9
	} phase_t;

	// result kind on the master side
	typedef enum logic [2:0] {
		KIND_SHORT     = 3'd0,
		KIND_META_HDR  = 3'd1,
		KIND_SYSEX_HDR = 3'd2,
		KIND_PAYLOAD   = 3'd3,
		KIND_ERROR     = 3'd4
	} kind_t;

	// status byte classes
	localparam logic [7:0] DATA_MASK   = 8'h7f;
	localparam logic [3:0] HI_NOTE_OFF = 4'h8;
	localparam logic [3:0] HI_NOTE_ON  = 4'h9;
	localparam logic [3:0] HI_POLY_AT  = 4'hA;
	localparam logic [3:0] HI_CTRL     = 4'hB;
	localparam logic [3:0] HI_PROG     = 4'hC;
	localparam logic [3:0] HI_CHAN_AT  = 4'hD;
	localparam logic [3:0] HI_BEND     = 4'hE;
	localparam logic [7:0] ST_SYSEX    = 8'hF0;
	localparam logic [7:0] ST_MTC_QF   = 8'hF1;
	localparam logic [7:0] ST_SONG_POS = 8'hF2;
	localparam logic [7:0] ST_SONG_SEL = 8'hF3;
	localparam logic [7:0] ST_TUNE     = 8'hF6;
	localparam logic [7:0] ST_ESCAPE   = 8'hF7;
	localparam logic [7:0] ST_META     = 8'hFF;

	typedef struct packed {
		logic [7:0]  payload_byte;
		logic [31:0] payload_length;
		logic [7:0]  data_two;
		logic [7:0]  data_one;
		logic [7:0]  status;
		logic [31:0] abs_tick;
		kind_t       kind;
		logic        event_last;
	} result_t;

endpackage

`default_nettype wire

@@ rtl/mtep_parse.sv @@
`default_nettype none

module mtep_parse #(
	parameter int TICK_BITS = 32
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               advance,
	input  wire  [7:0]        in_byte,
	input  wire               track_start,
	output logic              res_valid,
	output mtep_pkg::result_t res
);
	import mtep_pkg::*;

	phase_t                 phase_q, ph;
	logic [TICK_BITS-1:0]   tick_q, tick;
	logic [TICK_BITS-1:0]   delta_q, delta;
	logic [7:0]             rs_q, rs;
	logic [7:0]             cs_q, cs;
	logic [7:0]             fd_q, fd;
	logic [31:0]            len_q, len;
	logic [31:0]            rem_q, rem;
	logic [7:0]             sb;
	logic [3:0]             hi;
	logic                   do_body;
	logic [63:0]            tick_wide;

	always_comb begin
		// track start restores the reset view before the byte is handled
		if (track_start) begin
			ph    = PH_DELTA;
			tick  = '0;
			delta = '0;
			rs    = '0;
			cs    = '0;
			fd    = '0;
			len   = '0;
			rem   = '0;
		end else begin
			ph    = phase_q;
			tick  = tick_q;
			delta = delta_q;
			rs    = rs_q;
			cs    = cs_q;
			fd    = fd_q;
			len   = len_q;
			rem   = rem_q;
		end
		tick_wide = 64'(tick);

		res_valid          = 1'b0;
		res.kind           = KIND_SHORT;
		res.abs_tick       = tick_wide[31:0];
		res.status         = '0;
		res.data_one       = '0;
		res.data_two       = '0;
		res.payload_length = '0;
		res.payload_byte   = '0;
		res.event_last     = 1'b0;

		sb      = in_byte[7] ? in_byte : rs;
		hi      = sb[7:4];
		do_body = 1'b0;

		if (ph == PH_HALT) begin
			do_body = 1'b0;
		end else if (ph == PH_STATUS) begin
			if (in_byte[7]) begin
				rs = in_byte;
			end
			cs  = sb;
			fd  = '0;
			len = '0;
			rem = '0;
			do_body = !in_byte[7];
			if (hi == HI_NOTE_OFF || hi == HI_NOTE_ON || hi == HI_POLY_AT ||
			    hi == HI_CTRL || hi == HI_BEND || sb == ST_SONG_POS) begin
				ph = PH_DATA_A;
			end else if (hi == HI_PROG || hi == HI_CHAN_AT || sb == ST_MTC_QF ||
			             sb == ST_SONG_SEL) begin
				ph = PH_DATA_ONLY;
			end else if (sb == ST_TUNE) begin
				// no data bytes: emit now, a data byte here starts the next delta
				ph             = PH_DELTA;
				res_valid      = 1'b1;
				res.kind       = KIND_SHORT;
				res.status     = sb;
				res.event_last = 1'b1;
			end else if (sb == ST_META) begin
				ph = PH_META_TYPE;
			end else if (sb == ST_SYSEX || sb == ST_ESCAPE) begin
				ph = PH_SYSEX_LEN;
			end else begin
				ph             = PH_HALT;
				do_body        = 1'b0;
				res_valid      = 1'b1;
				res.kind       = KIND_ERROR;
				res.status     = sb;
				res.event_last = 1'b1;
			end
		end else begin
			do_body = 1'b1;
		end

		if (do_body) begin
			unique case (ph)
				PH_DELTA: begin
					delta = {delta[TICK_BITS-8:0], in_byte[6:0]};
					if (!in_byte[7]) begin
						tick  = tick + delta;
						delta = '0;
						ph    = PH_STATUS;
					end
				end
				PH_DATA_A: begin
					fd = in_byte;
					ph = PH_DATA_B;
				end
				PH_DATA_B: begin
					ph             = PH_DELTA;
					res_valid      = 1'b1;
					res.kind       = KIND_SHORT;
					res.status     = cs;
					res.data_one   = fd;
					res.data_two   = in_byte;
					res.event_last = 1'b1;
				end
				PH_DATA_ONLY: begin
					ph             = PH_DELTA;
					res_valid      = 1'b1;
					res.kind       = KIND_SHORT;
					res.status     = cs;
					res.data_one   = in_byte;
					res.event_last = 1'b1;
				end
				PH_META_TYPE: begin
					fd  = in_byte;
					len = '0;
					ph  = PH_META_LEN;
				end
				PH_META_LEN, PH_SYSEX_LEN: begin
					len = {len[24:0], in_byte[6:0]};
					if (!in_byte[7]) begin
						res_valid          = 1'b1;
						res.kind           = (ph == PH_META_LEN) ? KIND_META_HDR : KIND_SYSEX_HDR;
						res.status         = cs;
						res.data_one       = (ph == PH_META_LEN) ? fd : 8'h00;
						res.payload_length = len;
						res.event_last     = (len == '0);
						rem                = len;
						ph                 = (len == '0) ? PH_DELTA : PH_PAYLOAD;
					end
				end
				PH_PAYLOAD: begin
					rem                = rem - 32'd1;
					res_valid          = 1'b1;
					res.kind           = KIND_PAYLOAD;
					res.status         = cs;
					res.payload_length = len;
					res.payload_byte   = in_byte;
					res.event_last     = (rem == '0);
					if (rem == '0) begin
						ph = PH_DELTA;
					end
				end
				default: begin
					ph = ph;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_DELTA;
			tick_q  <= '0;
			delta_q <= '0;
			rs_q    <= '0;
			cs_q    <= '0;
			fd_q    <= '0;
			len_q   <= '0;
			rem_q   <= '0;
		end else if (advance) begin
			phase_q <= ph;
			tick_q  <= tick;
			delta_q <= delta;
			rs_q    <= rs;
			cs_q    <= cs;
			fd_q    <= fd;
			len_q   <= len;
			rem_q   <= rem;
		end
	end

endmodule

`default_nettype wire

@@ rtl/mtep_out_stage.sv @@
`default_nettype none

module mtep_out_stage (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               load,
	input  mtep_pkg::result_t res,
	input  wire               m_axis_tready,
	output logic              m_axis_tvalid,
	output mtep_pkg::result_t res_q,
	output logic              space
);
	import mtep_pkg::*;

	logic valid_q;

	// room for a new result when empty or the held one leaves this cycle
	assign space         = !valid_q || m_axis_tready;
	assign m_axis_tvalid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

endmodule

`default_nettype wire

@@ rtl/midi_track_event_parser_core.sv @@
// an accepted byte passes the input register, then the parse logic into the result
// register, before its result shows on the master side
// throughput: one byte per cycle, sustained while the master side keeps tready high
// asynchronous active-low reset empties both registers and puts the parser back to
// expecting a delta time, with tick, running status and length state cleared
`default_nettype none

module midi_track_event_parser_core #(
	parameter int TICK_BITS = 32
) (
	input  wire          clk,
	input  wire          arst_n,
	// slave side: one track byte per request
	input  wire          s_axis_tvalid,
	output logic         s_axis_tready,
	input  wire  [7:0]   s_axis_tdata,  // [7:0] in_byte
	input  wire  [0:0]   s_axis_tuser,  // [0] track_start
	// master side: one parsed result per request
	output logic         m_axis_tvalid,
	input  wire          m_axis_tready,
	output logic [95:0]  m_axis_tdata,  // [31:0] abs_tick, [39:32] status,
	                                    // [47:40] data_one, [55:48] data_two,
	                                    // [87:56] payload_length, [95:88] payload_byte
	output logic [2:0]   m_axis_tuser,  // [2:0] kind
	output logic         m_axis_tlast   // event_last
);
	import mtep_pkg::*;

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       start_s1;

	logic    advance;
	logic    space;
	logic    res_valid;
	result_t res;
	result_t res_q;

	// the registered byte is parsed once the result register has room,
	// even if this byte turns out to produce no result
	assign advance       = valid_s1 && space;
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	// payload of the input register needs no reset
	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1  <= s_axis_tdata;
			start_s1 <= s_axis_tuser[0];
		end
	end

	// phase tracking, varint decoding and tick accumulation
	mtep_parse #(
		.TICK_BITS (TICK_BITS)
	) u_parse (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (advance),
		.in_byte     (byte_s1),
		.track_start (start_s1),
		.res_valid   (res_valid),
		.res         (res)
	);

	// result register towards the master side
	mtep_out_stage u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (advance && res_valid),
		.res           (res),
		.m_axis_tready (m_axis_tready),
		.m_axis_tvalid (m_axis_tvalid),
		.res_q         (res_q),
		.space         (space)
	);

	assign m_axis_tdata = {res_q.payload_byte, res_q.payload_length, res_q.data_two,
	                       res_q.data_one, res_q.status, res_q.abs_tick};
	assign m_axis_tuser = res_q.kind;
	assign m_axis_tlast = res_q.event_last;

endmodule

`default_nettype wire

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
	import mtep_pkg::*;

	// how a status byte is parsed
	typedef enum int {
		EV_TWO_DATA,
		EV_ONE_DATA,
		EV_NO_DATA,
		EV_META,
		EV_SYSEX,
		EV_UNKNOWN
	} status_class_t;

	localparam int         QUIET_LIMIT       = 1000;
	localparam logic [7:0] ST_UNDEF_LO       = 8'hF4;
	localparam logic [7:0] ST_REALTIME_LO    = 8'hF8;
	localparam logic [7:0] META_END_OF_TRACK = 8'h2F;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] in_byte
	logic [0:0]  s_axis_tuser = 1'b0;    // [0] track_start
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [95:0] m_axis_tdata;           // abs_tick, status, data_one, data_two,
	                                     // payload_length, payload_byte
	logic [2:0]  m_axis_tuser;           // [2:0] kind
	logic        m_axis_tlast;           // event_last

	midi_track_event_parser_core i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// parser state as the testbench sees it
	phase_t      parse_phase;
	logic [31:0] tick_total;
	logic [31:0] delta_accum;
	logic [7:0]  run_status;
	logic [7:0]  cur_status;
	logic [7:0]  first_data;
	logic [31:0] len_accum;
	logic [31:0] bytes_left;

	result_t     track_events_due[$];
	int          mismatches = 0;
	int unsigned fed_items = 0;
	bit          src_gaps = 1'b0;
	bit          sink_stalls = 1'b0;

	function automatic status_class_t classify(input logic [7:0] s);
		case (s[7:4])
			HI_NOTE_OFF, HI_NOTE_ON, HI_POLY_AT, HI_CTRL, HI_BEND: return EV_TWO_DATA;
			HI_PROG, HI_CHAN_AT: return EV_ONE_DATA;
			default: ;
		endcase
		if (s == ST_SONG_POS)
			return EV_TWO_DATA;
		if (s == ST_MTC_QF || s == ST_SONG_SEL)
			return EV_ONE_DATA;
		if (s == ST_TUNE)
			return EV_NO_DATA;
		if (s == ST_META)
			return EV_META;
		if (s == ST_SYSEX || s == ST_ESCAPE)
			return EV_SYSEX;
		return EV_UNKNOWN;
	endfunction

	function automatic void clear_parser_state();
		parse_phase = PH_DELTA;
		tick_total  = '0;
		delta_accum = '0;
		run_status  = '0;
		cur_status  = '0;
		first_data  = '0;
		len_accum   = '0;
		bytes_left  = '0;
	endfunction

	function automatic void push_event(input kind_t k, input logic [7:0] d1,
			input logic [7:0] d2, input logic [31:0] len, input logic [7:0] pb,
			input logic last);
		result_t r;
		r.kind           = k;
		r.abs_tick       = tick_total;
		r.status         = cur_status;
		r.data_one       = d1;
		r.data_two       = d2;
		r.payload_length = len;
		r.payload_byte   = pb;
		r.event_last     = last;
		track_events_due = {track_events_due, r};
	endfunction

	// status byte seen: pick the phase, no-data and unknown statuses emit at once
	function automatic void start_event(input logic [7:0] s);
		cur_status = s;
		first_data = '0;
		len_accum  = '0;
		bytes_left = '0;
		case (classify(s))
			EV_TWO_DATA: parse_phase = PH_DATA_A;
			EV_ONE_DATA: parse_phase = PH_DATA_ONLY;
			EV_NO_DATA: begin
				parse_phase = PH_DELTA;
				push_event(KIND_SHORT, 8'h00, 8'h00, 32'h0, 8'h00, 1'b1);
			end
			EV_META: parse_phase = PH_META_TYPE;
			EV_SYSEX: parse_phase = PH_SYSEX_LEN;
			default: begin
				parse_phase = PH_HALT;
				push_event(KIND_ERROR, 8'h00, 8'h00, 32'h0, 8'h00, 1'b1);
			end
		endcase
	endfunction

	function automatic void body_byte(input logic [7:0] b);
		kind_t hdr_kind;
		case (parse_phase)
			PH_DELTA: begin
				delta_accum = {delta_accum[24:0], b[6:0]};
				if (!b[7]) begin
					tick_total  = tick_total + delta_accum;
					delta_accum = '0;
					parse_phase = PH_STATUS;
				end
			end
			PH_DATA_A: begin
				first_data  = b;
				parse_phase = PH_DATA_B;
			end
			PH_DATA_B: begin
				parse_phase = PH_DELTA;
				push_event(KIND_SHORT, first_data, b, 32'h0, 8'h00, 1'b1);
			end
			PH_DATA_ONLY: begin
				parse_phase = PH_DELTA;
				push_event(KIND_SHORT, b, 8'h00, 32'h0, 8'h00, 1'b1);
			end
			PH_META_TYPE: begin
				first_data  = b;
				len_accum   = '0;
				parse_phase = PH_META_LEN;
			end
			PH_META_LEN, PH_SYSEX_LEN: begin
				len_accum = {len_accum[24:0], b[6:0]};
				if (!b[7]) begin
					bytes_left = len_accum;
					if (parse_phase == PH_META_LEN) begin
						hdr_kind = KIND_META_HDR;
					end else begin
						hdr_kind = KIND_SYSEX_HDR;
						first_data = '0;
					end
					push_event(hdr_kind, first_data, 8'h00, len_accum, 8'h00,
						len_accum == 0);
					parse_phase = (len_accum == 0) ? PH_DELTA : PH_PAYLOAD;
				end
			end
			PH_PAYLOAD: begin
				bytes_left = bytes_left - 1;
				if (bytes_left == 0)
					parse_phase = PH_DELTA;
				push_event(KIND_PAYLOAD, 8'h00, 8'h00, len_accum, b, bytes_left == 0);
			end
			default: ;
		endcase
	endfunction

	// expected results for one accepted track byte
	function automatic void parse_track_byte(input logic [7:0] b, input bit start);
		if (start)
			clear_parser_state();
		if (parse_phase == PH_HALT)
			return;
		fed_items++;
		if (parse_phase != PH_STATUS) begin
			body_byte(b);
		end else if (b[7]) begin
			run_status = b;
			start_event(b);
		end else begin
			// running status: the data byte goes on to the event body
			start_event(run_status);
			if (parse_phase != PH_HALT)
				body_byte(b);
		end
	endfunction

	// mostly short idles, now and then a long one
	function automatic int idle_length();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
	endfunction

	function automatic logic [7:0] data_byte(input bit allow_high);
		if (allow_high && $urandom_range(0, 5) == 0)
			return 8'($urandom_range(128, 255));
		return 8'($urandom_range(0, 127));
	endfunction

	task automatic send_byte(input logic [7:0] b, input bit start);
		int gap;
		gap = 0;
		if (src_gaps && $urandom_range(0, 99) < 30)
			gap = idle_length();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tuser  <= start;
		do @(posedge clk); while (!s_axis_tready);
		parse_track_byte(b, start);
	endtask

	// seven bits per byte, msb group first; pad adds leading zero groups, junk
	// puts a group in front that gets shifted out of the 32-bit accumulator
	task automatic send_varint(input logic [31:0] v, input int pad, input bit junk,
			input bit start);
		int n;
		logic [7:0] b;
		n = 1;
		while (n < 5 && (v >> (7 * n)) != 0)
			n++;
		n = n + pad;
		if (junk) begin
			n = 5;
			send_byte(8'h80 | 8'($urandom_range(0, 127)), start);
			start = 1'b0;
		end
		for (int g = n - 1; g >= 0; g--) begin
			b = 8'((v >> (7 * g)) & 32'h7f);
			if (g != 0)
				b[7] = 1'b1;
			send_byte(b, start);
			start = 1'b0;
		end
	endtask

	task automatic send_delta(input bit start);
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			send_varint($urandom_range(0, 127), $urandom_range(0, 9) == 0, 1'b0, start);
		else if (r < 85)
			send_varint($urandom_range(0, (1 << 21) - 1), 0, 1'b0, start);
		else if (r < 95)
			send_varint($urandom, 0, 1'b0, start);
		else
			send_varint($urandom, 0, 1'b1, start);
	endtask

	// a length that fits one byte when it has to stand in the status position
	task automatic send_length_and_payload(input bit plain_length);
		logic [31:0] len;
		int r;
		r = $urandom_range(0, 99);
		if (r < 10)
			len = 0;
		else if (r < 85)
			len = $urandom_range(1, 6);
		else
			len = $urandom_range(7, 40);
		if (plain_length)
			send_varint(len, 0, 1'b0, 1'b0);
		else
			send_varint(len, $urandom_range(0, 7) == 0, $urandom_range(0, 15) == 0, 1'b0);
		repeat (len) send_byte(8'($urandom_range(0, 255)), 1'b0);
	endtask

	task automatic send_event(input bit start);
		logic [7:0] s;
		logic [3:0] hi;
		bit running;
		int r;
		send_delta(start);
		running = classify(run_status) != EV_NO_DATA && classify(run_status) != EV_UNKNOWN
			&& $urandom_range(0, 4) == 0;
		if (running) begin
			s = run_status;
		end else begin
			r = $urandom_range(0, 99);
			if (r < 35) begin
				case ($urandom_range(0, 4))
					0: hi = HI_NOTE_OFF;
					1: hi = HI_NOTE_ON;
					2: hi = HI_POLY_AT;
					3: hi = HI_CTRL;
					default: hi = HI_BEND;
				endcase
				s = {hi, 4'($urandom)};
			end else if (r < 50) begin
				s = {($urandom_range(0, 1) == 0) ? HI_PROG : HI_CHAN_AT, 4'($urandom)};
			end else if (r < 56) begin
				s = ST_SONG_POS;
			end else if (r < 59) begin
				s = ST_MTC_QF;
			end else if (r < 62) begin
				s = ST_SONG_SEL;
			end else if (r < 67) begin
				s = ST_TUNE;
			end else if (r < 82) begin
				s = ST_META;
			end else if (r < 91) begin
				s = ST_SYSEX;
			end else begin
				s = ST_ESCAPE;
			end
			send_byte(s, 1'b0);
		end
		case (classify(s))
			EV_TWO_DATA: begin
				send_byte(data_byte(!running), 1'b0);
				send_byte(data_byte(1'b1), 1'b0);
			end
			EV_ONE_DATA: send_byte(data_byte(!running), 1'b0);
			EV_META: begin
				send_byte(data_byte(!running), 1'b0);
				send_length_and_payload(1'b0);
			end
			EV_SYSEX: send_length_and_payload(running);
			default: ;
		endcase
	endtask

	task automatic send_noise(input bit start);
		int k;
		case ($urandom_range(0, 3))
			0: begin
				// undefined or real-time status byte
				send_varint($urandom_range(0, 127), 0, 1'b0, start);
				k = $urandom_range(0, 8);
				send_byte((k < 2) ? ST_UNDEF_LO + 8'(k) : ST_REALTIME_LO + 8'(k - 2), 1'b0);
			end
			1: begin
				repeat ($urandom_range(1, 4)) begin
					send_byte(8'($urandom_range(0, 255)), start || $urandom_range(0, 7) == 0);
					start = 1'b0;
				end
			end
			2: begin
				// event cut short, the next one restarts the track
				send_varint($urandom_range(0, 127), 0, 1'b0, start);
				send_byte({HI_NOTE_ON, 4'($urandom)}, 1'b0);
				send_byte(data_byte(1'b0), 1'b0);
			end
			default: begin
				// running status with no status seen yet
				send_varint(0, 0, 1'b0, 1'b1);
				send_byte(data_byte(1'b0), 1'b0);
			end
		endcase
	endtask

	task automatic test_short_events();
		src_gaps    = 1'b1;
		sink_stalls = 1'b1;
		send_byte(8'h00, 1'b1);
		send_byte({HI_NOTE_ON, 4'h0}, 1'b0);
		send_byte(8'h3c, 1'b0);
		send_byte(8'he4, 1'b0);             // data byte with bit 7 set
		send_byte(8'h81, 1'b0);             // multi-byte delta
		send_byte(8'h80, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h3c, 1'b0);             // running status note
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(ST_TUNE, 1'b0);
		send_byte(8'h10, 1'b0);             // delta after the tune request, which takes no data bytes
		send_byte({HI_PROG, 4'h5}, 1'b0);
		send_byte(8'h05, 1'b0);
	endtask

	task automatic test_meta_and_sysex();
		send_byte(8'h00, 1'b1);
		send_byte(ST_META, 1'b0);
		send_byte(META_END_OF_TRACK, 1'b0);
		send_byte(8'h00, 1'b0);             // zero length, header closes the event
		send_byte(8'h00, 1'b0);
		send_byte(ST_SYSEX, 1'b0);
		send_byte(8'h02, 1'b0);
		send_byte(ST_ESCAPE, 1'b0);
		send_byte(8'haa, 1'b0);
	endtask

	task automatic test_unknown_status();
		send_byte(8'h00, 1'b1);
		send_byte(ST_UNDEF_LO, 1'b0);
		send_byte(8'h55, 1'b0);             // ignored while halted
		send_byte(8'h00, 1'b1);
		send_byte(8'h40, 1'b0);             // running status before any status
	endtask

	task automatic test_random_track(input int unsigned items, input bit gaps,
			input bit stalls);
		bit start;
		src_gaps    = gaps;
		sink_stalls = stalls;
		fed_items   = 0;
		while (fed_items < items) begin
			if (parse_phase == PH_HALT)
				repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)), 1'b0);
			start = parse_phase != PH_DELTA || $urandom_range(0, 49) == 0;
			if ($urandom_range(0, 99) < 8)
				send_noise(start);
			else
				send_event(start);
		end
	endtask

	// receiver pacing on the master side
	initial begin : sink_pacing
		int hold;
		hold = 0;
		forever begin
			@(posedge clk);
			if (hold > 0) begin
				hold--;
				m_axis_tready <= 1'b0;
			end else if (sink_stalls && $urandom_range(0, 99) < 30) begin
				hold = idle_length() - 1;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0h actual %0h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin : check_results
		result_t want;
		if (m_axis_tvalid && m_axis_tready) begin
			if (track_events_due.size() == 0) begin
				$display("%0t: result expected none actual tdata %h tuser %0h tlast %b",
					$time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
				mismatches++;
			end else begin
				want = track_events_due.pop_front();
				check_field("kind", 32'(want.kind), 32'(m_axis_tuser));
				check_field("abs_tick", want.abs_tick, m_axis_tdata[31:0]);
				check_field("status", 32'(want.status), 32'(m_axis_tdata[39:32]));
				check_field("data_one", 32'(want.data_one), 32'(m_axis_tdata[47:40]));
				check_field("data_two", 32'(want.data_two), 32'(m_axis_tdata[55:48]));
				check_field("payload_length", want.payload_length, m_axis_tdata[87:56]);
				check_field("payload_byte", 32'(want.payload_byte), 32'(m_axis_tdata[95:88]));
				check_field("event_last", 32'(want.event_last), 32'(m_axis_tlast));
			end
		end
	end

	// ends the run when no request moves on either side for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("midi_track_event_parser_core: mismatch");
		$finish;
	end

	initial begin
		clear_parser_state();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_short_events();
		test_meta_and_sysex();
		test_unknown_status();
		test_random_track(120, 1'b0, 1'b0);
		test_random_track(400, 1'b1, 1'b1);
		test_random_track(120, 1'b1, 1'b0);
		test_random_track(120, 1'b0, 1'b1);
		s_axis_tvalid <= 1'b0;
		while (track_events_due.size() != 0)
			@(posedge clk);
		// two-stage pipe, leave room for anything stray
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("midi_track_event_parser_core: match");
		else
			$display("midi_track_event_parser_core: mismatch");
		$finish;
	end

endmodule
